FILE: design/ccde_pkg.sv
`timescale 1ns / 1ps

package ccde_pkg;

  localparam int RGB_W       = 24;
  localparam int PAT_W       = 64;
  localparam int IDX_W       = 8;
  localparam int PAL_SIZE    = 4;
  localparam int PAL_IDX_W   = 2;
  localparam int PAL_CNT_W   = 3;
  localparam int POS_W       = 5;
  localparam int CELL_LAST   = 31;

  typedef enum logic {
    ST_PIXEL,
    ST_CELL
  } ccde_top_state_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_SCAN,
    SR_DONE
  } ccde_srch_state_t;

  typedef struct packed {
    logic [PAL_IDX_W-1:0] idx;
    logic                 miss_full;
  } ccde_pal_res_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
    logic             is_new;
    logic             full;
  } ccde_srch_res_t;

endpackage

FILE: design/ccde_palette.sv
`timescale 1ns / 1ps

module ccde_palette (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        update,
  input  logic [ccde_pkg::RGB_W-1:0]  rgb,
  output ccde_pkg::ccde_pal_res_t     res
);

  logic [ccde_pkg::RGB_W-1:0]     pal_r [ccde_pkg::PAL_SIZE];
  logic [ccde_pkg::PAL_CNT_W-1:0] cnt_r;
  logic [ccde_pkg::PAL_CNT_W-1:0] cnt_eff;
  logic [ccde_pkg::PAL_CNT_W-1:0] cnt_nxt;
  logic                           hit;
  logic [ccde_pkg::PAL_IDX_W-1:0] hit_idx;
  logic                           store;

  assign cnt_eff = clear ? '0 : cnt_r;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ccde_pkg::PAL_SIZE - 1; i >= 0; i--) begin
      if ((ccde_pkg::PAL_CNT_W'(i) < cnt_eff) && (pal_r[i] == rgb)) begin
        hit     = 1'b1;
        hit_idx = ccde_pkg::PAL_IDX_W'(i);
      end
    end
  end

  always_comb begin
    store         = 1'b0;
    cnt_nxt       = cnt_eff;
    res.miss_full = 1'b0;
    res.idx       = hit_idx;
    if (!hit) begin
      if (cnt_eff < ccde_pkg::PAL_CNT_W'(ccde_pkg::PAL_SIZE)) begin
        store   = 1'b1;
        res.idx = cnt_eff[ccde_pkg::PAL_IDX_W-1:0];
        cnt_nxt = cnt_eff + 1'b1;
      end else begin
        res.idx       = ccde_pkg::PAL_IDX_W'(ccde_pkg::PAL_SIZE - 1);
        res.miss_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (update) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (update && store) begin
      pal_r[cnt_eff[ccde_pkg::PAL_IDX_W-1:0]] <= rgb;
    end
  end

endmodule

FILE: design/ccde_search.sv
`timescale 1ns / 1ps

module ccde_search #(
  parameter int CHARSET_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        start,
  input  logic [ccde_pkg::PAT_W-1:0]  pattern,
  input  logic                        ack,
  output ccde_pkg::ccde_srch_res_t    res
);

  localparam int AW = $clog2(CHARSET_DEPTH);
  localparam int CW = $clog2(CHARSET_DEPTH + 1);

  logic [ccde_pkg::PAT_W-1:0] mem [CHARSET_DEPTH];

  ccde_pkg::ccde_srch_state_t state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              iss_r, iss_nxt;
  logic [ccde_pkg::PAT_W-1:0] pat_r;
  logic [ccde_pkg::PAT_W-1:0] rd_q_r;
  logic                       cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]              cmp_idx_r;
  logic [ccde_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       new_r, new_nxt;
  logic                       full_r, full_nxt;
  logic                       hit;
  logic                       last;
  logic                       wr_en;

  assign hit  = cmp_v_r && (rd_q_r == pat_r);
  assign last = cmp_v_r && ((CW'(cmp_idx_r) + 1'b1) == count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = clear ? '0 : count_r;
    iss_nxt   = iss_r;
    cmp_v_nxt = 1'b0;
    idx_nxt   = idx_r;
    new_nxt   = new_r;
    full_nxt  = full_r;
    wr_en     = 1'b0;
    unique case (state_r)
      ccde_pkg::SR_IDLE: begin
        iss_nxt = '0;
        if (start) begin
          state_nxt = ccde_pkg::SR_SCAN;
        end
      end
      ccde_pkg::SR_SCAN: begin
        if (iss_r < count_r) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (hit) begin
          idx_nxt   = ccde_pkg::IDX_W'(cmp_idx_r);
          new_nxt   = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = ccde_pkg::SR_DONE;
        end else if (last || (count_r == '0)) begin
          state_nxt = ccde_pkg::SR_DONE;
          if (count_r < CW'(CHARSET_DEPTH)) begin
            wr_en     = 1'b1;
            idx_nxt   = ccde_pkg::IDX_W'(count_r[AW-1:0]);
            new_nxt   = 1'b1;
            full_nxt  = 1'b0;
            count_nxt = count_r + 1'b1;
          end else begin
            idx_nxt  = '0;
            new_nxt  = 1'b0;
            full_nxt = 1'b1;
          end
        end else begin
          cmp_v_nxt = iss_r < count_r;
        end
      end
      ccde_pkg::SR_DONE: begin
        if (ack) begin
          state_nxt = ccde_pkg::SR_IDLE;
        end
      end
      default: state_nxt = ccde_pkg::SR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccde_pkg::SR_IDLE;
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r     <= iss_nxt;
    idx_r     <= idx_nxt;
    new_r     <= new_nxt;
    full_r    <= full_nxt;
    cmp_idx_r <= iss_r[AW-1:0];
    if (state_r == ccde_pkg::SR_IDLE && start) begin
      pat_r <= pattern;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[iss_r[AW-1:0]];
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= pat_r;
    end
  end

  assign res.done   = (state_r == ccde_pkg::SR_DONE);
  assign res.index  = idx_r;
  assign res.is_new = new_r;
  assign res.full   = full_r;

endmodule

FILE: design/char_cell_dedup_encoder_top.sv
`timescale 1ns / 1ps
// Pixel words: one cycle each, in_tready stays high until the last pixel of a cell.
// Last pixel of a cell: the pattern scan reads one stored character per cycle
// (up to CHARSET_DEPTH stored characters), and in_tready is low until the cell
// result leaves into the output register.
// Synchronous active-low reset empties palette, character set and cell state.
module char_cell_dedup_encoder_top #(
  parameter int CHARSET_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_rgb[23:0]
  input  logic [0:0]  in_tuser,   // new_image
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // char_index[7:0], char_pattern[71:8]
  output logic [2:0]  out_tuser   // is_new_char, colour_overflow, charset_full
);

  ccde_pkg::ccde_top_state_t  state_r, state_nxt;
  ccde_pkg::ccde_pal_res_t    pal_res;
  ccde_pkg::ccde_srch_res_t   srch_res;

  logic [ccde_pkg::PAT_W-1:0] bits_r, bits_eff, bits_new;
  logic [ccde_pkg::POS_W-1:0] pos_r, pos_eff;
  logic                       ovf_r, ovf_eff, ovf_new;
  logic [5:0]                 shift;
  logic                       accept;
  logic                       clear;
  logic                       cell_end;
  logic                       start;
  logic                       emit;
  logic [ccde_pkg::PAT_W-1:0] held_pat_r;
  logic                       held_ovf_r;
  logic                       out_v_r;
  logic [71:0]                out_data_r;
  logic [2:0]                 out_user_r;

  assign in_tready = (state_r == ccde_pkg::ST_PIXEL);
  assign accept    = in_tvalid && in_tready;
  assign clear     = accept && in_tuser[0];

  assign pos_eff  = in_tuser[0] ? '0 : pos_r;
  assign bits_eff = in_tuser[0] ? '0 : bits_r;
  assign ovf_eff  = in_tuser[0] ? 1'b0 : ovf_r;
  assign shift    = {~pos_eff[4:2], ~pos_eff[1:0], 1'b0};
  assign bits_new = bits_eff | ({{(ccde_pkg::PAT_W - ccde_pkg::PAL_IDX_W){1'b0}}, pal_res.idx}
                                << shift);
  assign ovf_new  = ovf_eff | pal_res.miss_full;
  assign cell_end = (pos_eff == ccde_pkg::POS_W'(ccde_pkg::CELL_LAST));
  assign start    = accept && cell_end;
  assign emit     = (state_r == ccde_pkg::ST_CELL) && srch_res.done &&
                    (!out_v_r || out_tready);

  ccde_palette u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (clear),
    .update (accept),
    .rgb    (in_tdata),
    .res    (pal_res)
  );

  ccde_search #(
    .CHARSET_DEPTH (CHARSET_DEPTH)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear),
    .start   (start),
    .pattern (bits_new),
    .ack     (emit),
    .res     (srch_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccde_pkg::ST_PIXEL: if (start) state_nxt = ccde_pkg::ST_CELL;
      ccde_pkg::ST_CELL:  if (emit) state_nxt = ccde_pkg::ST_PIXEL;
      default:            state_nxt = ccde_pkg::ST_PIXEL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccde_pkg::ST_PIXEL;
      pos_r   <= '0;
      bits_r  <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (cell_end) begin
          pos_r  <= '0;
          bits_r <= '0;
          ovf_r  <= 1'b0;
        end else begin
          pos_r  <= pos_eff + 1'b1;
          bits_r <= bits_new;
          ovf_r  <= ovf_new;
        end
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      held_pat_r <= bits_new;
      held_ovf_r <= ovf_new;
    end
    if (emit) begin
      out_data_r <= {held_pat_r, srch_res.index};
      out_user_r <= {srch_res.full, held_ovf_r, srch_res.is_new};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: sim/tb_char_cell_dedup_encoder_top.sv
`timescale 1ns / 1ps

module tb_char_cell_dedup_encoder_top;

  localparam int RGB_W         = ccde_pkg::RGB_W;
  localparam int PAT_W         = ccde_pkg::PAT_W;
  localparam int IDX_W         = ccde_pkg::IDX_W;
  localparam int PAL_SIZE      = ccde_pkg::PAL_SIZE;
  localparam int PAL_IDX_W     = ccde_pkg::PAL_IDX_W;
  localparam int CELL_LAST     = ccde_pkg::CELL_LAST;
  localparam int CHARSET_DEPTH = 16;
  localparam int CELL_PIXELS   = CELL_LAST + 1;
  localparam int PHASE_ITEMS   = 283;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = CHARSET_DEPTH + 40;
  localparam int LONG_HOLD     = 600;

  typedef logic [CELL_PIXELS*RGB_W-1:0] cell_pixels_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic             is_new;
    logic [PAT_W-1:0] pattern;
    logic             overflow;
    logic             full;
  } cell_result_t;

  class cell_scoreboard;
    int               depth;
    logic [RGB_W-1:0] palette[PAL_SIZE];
    int               pal_used;
    logic [PAT_W-1:0] charset[$];
    logic [PAT_W-1:0] cell_bits;
    int               pos;
    bit               overflow;
    cell_result_t     due[$];
    int               errors;

    function new(int d);
      depth = d;
      pal_used = 0;
      cell_bits = '0;
      pos = 0;
      overflow = 0;
      errors = 0;
    endfunction

    function void note_pixel(logic [RGB_W-1:0] rgb, bit new_img);
      int           idx;
      int           hit;
      int           k;
      cell_result_t r;
      if (new_img) begin
        pal_used = 0;
        charset.delete();
        cell_bits = '0;
        pos = 0;
        overflow = 0;
      end
      idx = -1;
      for (k = 0; k < pal_used; k++)
        if (idx < 0 && palette[k] == rgb) idx = k;
      if (idx < 0) begin
        if (pal_used < PAL_SIZE) begin
          palette[pal_used] = rgb;
          idx = pal_used;
          pal_used++;
        end else begin
          idx = PAL_SIZE - 1;
          overflow = 1;
        end
      end
      cell_bits |= PAT_W'(idx) << ((7 - pos / 4) * 8 + 6 - PAL_IDX_W * (pos % 4));
      if (pos < CELL_LAST) begin
        pos++;
        return;
      end
      hit = -1;
      foreach (charset[j])
        if (hit < 0 && charset[j] == cell_bits) hit = j;
      r.is_new = 0;
      r.full = 0;
      if (hit < 0) begin
        if (charset.size() < depth) begin
          hit = charset.size();
          charset.push_back(cell_bits);
          r.is_new = 1;
        end else begin
          hit = 0;
          r.full = 1;
        end
      end
      r.index = IDX_W'(hit);
      r.pattern = cell_bits;
      r.overflow = overflow;
      due.push_back(r);
      cell_bits = '0;
      pos = 0;
      overflow = 0;
    endfunction

    function void check_result(logic [71:0] data, logic [2:0] flags);
      cell_result_t r;
      if (due.size() == 0) begin
        $display("%0t: unexpected word, data %h flags %b", $time, data, flags);
        errors++;
        return;
      end
      r = due.pop_front();
      if (data[7:0] !== r.index) begin
        $display("%0t: char_index expected %0d got %0d", $time, r.index, data[7:0]);
        errors++;
      end
      if (data[71:8] !== r.pattern) begin
        $display("%0t: char_pattern expected %h got %h", $time, r.pattern, data[71:8]);
        errors++;
      end
      if (flags[0] !== r.is_new) begin
        $display("%0t: is_new_char expected %b got %b", $time, r.is_new, flags[0]);
        errors++;
      end
      if (flags[1] !== r.overflow) begin
        $display("%0t: colour_overflow expected %b got %b", $time, r.overflow, flags[1]);
        errors++;
      end
      if (flags[2] !== r.full) begin
        $display("%0t: charset_full expected %b got %b", $time, r.full, flags[2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;

  cell_scoreboard sb = new(CHARSET_DEPTH);

  int snd_idle = 0;
  int rcv_idle = 0;
  int cycles = 0;
  int hold_left = 0;
  int words_seen = 0;
  bit hold_done = 0;

  logic [RGB_W-1:0] pool[5];
  cell_pixels_t     history[$];
  int               cells_left = 0;

  char_cell_dedup_encoder_top #(
    .CHARSET_DEPTH(CHARSET_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stall the result side; one long hold once a dozen cells are through
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) words_seen <= words_seen + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && words_seen == 12) begin
        hold_left <= LONG_HOLD;
        hold_done <= 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic send_pixel(logic [RGB_W-1:0] rgb, bit new_img);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= rgb;
    in_tuser <= new_img;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(rgb, new_img);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic send_cell(cell_pixels_t c, bit new_img);
    int p;
    for (p = 0; p < CELL_PIXELS; p++)
      send_pixel(c[p*RGB_W +: RGB_W], new_img && p == 0);
  endtask

  task automatic run_cells(int n_items);
    int           sent;
    int           kind;
    int           k;
    int           p;
    bit           start_img;
    logic [23:0]  a;
    logic [23:0]  b;
    cell_pixels_t c;
    sent = 0;
    while (sent < n_items) begin
      start_img = (cells_left == 0);
      if (start_img) begin
        for (k = 0; k < 5; k++) pool[k] = RGB_W'($urandom());
        cells_left = $urandom_range(18, 30);
        history.delete();
      end
      kind = $urandom_range(99);
      if (kind < 5 && !start_img) begin
        // broken cell: cut short, then restart the image
        k = $urandom_range(1, CELL_LAST);
        for (p = 0; p < k; p++) send_pixel(pool[$urandom_range(3)], 1'b0);
        sent += k;
        cells_left = 0;
      end else begin
        a = pool[$urandom_range(3)];
        b = pool[$urandom_range(3)];
        for (p = 0; p < CELL_PIXELS; p++) begin
          if (kind < 50) c[p*RGB_W +: RGB_W] = $urandom_range(1) ? a : b;
          else if (kind < 56) c[p*RGB_W +: RGB_W] = RGB_W'($urandom());
          else c[p*RGB_W +: RGB_W] = pool[$urandom_range(0, kind < 70 ? 4 : 3)];
        end
        if (kind < 40 && history.size() > 0) c = history[$urandom_range(history.size() - 1)];
        send_cell(c, start_img);
        history.push_back(c);
        sent += CELL_PIXELS;
        cells_left--;
      end
    end
  endtask

  initial begin
    logic [RGB_W-1:0] extremes[5];
    cell_pixels_t     c;
    int               p;
    extremes[0] = 24'h000000;
    extremes[1] = 24'hFFFFFF;
    extremes[2] = 24'h800000;
    extremes[3] = 24'h000001;
    extremes[4] = 24'h7FFFFF;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of the colour range and a fifth colour in one cell
    for (p = 0; p < CELL_PIXELS; p++) c[p*RGB_W +: RGB_W] = extremes[(p * 3 + p / 4) % 5];
    send_cell(c, 1'b1);
    drain();

    snd_idle = 14;
    rcv_idle = 59;
    run_cells(PHASE_ITEMS);
    drain();

    snd_idle = 59;
    rcv_idle = 14;
    run_cells(PHASE_ITEMS);
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    run_cells(PHASE_ITEMS);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
